// ===== design/stdg_pkg.sv =====
package stdg_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_START_VOLUME   = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_CEILING = 2'd1;
    localparam logic [1:0] CFG_DECAY_BEGIN    = 2'd2;
    localparam logic [1:0] CFG_DECAY_LIMIT    = 2'd3;

    // register reset values
    localparam logic [7:0] RST_START_VOLUME   = 8'd200;
    localparam logic [7:0] RST_OUTPUT_CEILING = 8'd200;
    localparam logic [7:0] RST_DECAY_BEGIN    = 8'd200;
    localparam logic [7:0] RST_DECAY_LIMIT    = 8'd220;

    // input command codes (carried on tuser)
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // sine table, one period
    localparam int WAVE_ENTRIES = 16;
    localparam logic [7:0] WAVE_TABLE [WAVE_ENTRIES] = '{
        8'd176, 8'd217, 8'd244, 8'd254, 8'd244, 8'd217, 8'd176, 8'd128,
        8'd80,  8'd39,  8'd12,  8'd2,   8'd12,  8'd39,  8'd80,  8'd128
    };

    // level / 50 for 8-bit level: (level * 1311) >> 16, exact over 0..255
    localparam logic [10:0] DIV50_MUL = 11'd1311;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    // one word handed from the input register to the envelope
    typedef struct packed {
        logic        fire;   // word is processed this cycle
        logic        start;  // start of a new note
        logic [15:0] len;    // note length in table periods
    } t_env_ctl;

endpackage

// ===== design/stdg_sample.sv =====
module stdg_sample (
    input  logic [3:0] i_entry_idx,
    input  logic [7:0] i_level,
    input  logic [7:0] i_ceiling,
    output logic [7:0] o_sample
);
    import stdg_pkg::*;

    logic [15:0] prod;
    logic [7:0]  scaled;

    // table entry times volume, keep the upper byte
    assign prod   = WAVE_TABLE[i_entry_idx] * i_level;
    assign scaled = prod[15:8];

    // clip to the ceiling
    assign o_sample = (scaled > i_ceiling) ? i_ceiling : scaled;

endmodule

// ===== design/stdg_env.sv =====
module stdg_env #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stdg_pkg::t_env_ctl i_ctl,
    input  logic [7:0]         i_start_volume,
    input  logic [7:0]         i_decay_begin,
    input  logic [7:0]         i_decay_limit,
    output logic [3:0]         o_entry_idx,
    output logic [7:0]         o_level,
    output logic               o_busy_next
);
    import stdg_pkg::*;

    localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [PW-1:0] PHASE_LAST = PW'(TABLE_DEPTH - 1);

    logic [PW-1:0] r_phase, n_phase;
    logic [15:0]   r_periods, n_periods;
    logic [7:0]    r_level, n_level;
    logic [7:0]    r_step, n_step;
    logic [7:0]    r_count, n_count;

    logic [PW+3:0] phase_ext;
    logic [18:0]   div_prod;
    logic [7:0]    level_div50;
    logic [7:0]    count_inc;
    logic [7:0]    step_use;
    logic [7:0]    level_dec;

    // table is read at phase mod 16
    assign phase_ext   = {4'b0, r_phase};
    assign o_entry_idx = phase_ext[3:0];
    assign o_level     = r_level;

    // period-end arithmetic
    assign div_prod    = r_level * DIV50_MUL;
    assign level_div50 = {5'b0, div_prod[18:16]};
    assign count_inc   = (r_count != COUNT_MAX) ? r_count + 8'd1 : r_count;
    assign step_use    = (r_step == 8'd0) ? level_div50 : r_step;
    assign level_dec   = (r_level > step_use) ? r_level - step_use : 8'd0;

    // next state for one word
    always_comb begin
        n_phase   = r_phase;
        n_periods = r_periods;
        n_level   = r_level;
        n_step    = r_step;
        n_count   = r_count;
        if (i_ctl.fire) begin
            if (i_ctl.start) begin
                n_level   = i_start_volume;
                n_count   = 8'd0;
                n_phase   = '0;
                n_periods = i_ctl.len;
            end else if (r_phase < PHASE_LAST) begin
                n_phase = r_phase + PW'(1);
            end else if (r_periods != 16'd0) begin
                n_phase   = '0;
                n_periods = r_periods - 16'd1;
                n_count   = count_inc;
                if (count_inc >= i_decay_begin) begin
                    n_level = level_dec;
                    if (level_dec <= step_use || count_inc >= i_decay_limit) begin
                        n_step  = 8'd0;
                        n_count = 8'd0;
                    end else begin
                        n_step = step_use;
                    end
                end
            end
        end
    end

    assign o_busy_next = (n_periods != 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PHASE_LAST;
            r_periods <= 16'd0;
            r_level   <= 8'd0;
            r_step    <= 8'd0;
            r_count   <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_periods <= n_periods;
            r_level   <= n_level;
            r_step    <= n_step;
            r_count   <= n_count;
        end
    end

endmodule

// ===== design/sine_tone_decay_generator_top.sv =====
// Channel   Dir  tdata              tuser
// s_axis    in   [15:0] note_length [0] cmd (0 tick, 1 start)
// m_axis    out  [7:0]  sample      [0] busy_res
// cfg       in   i_cfg_idx selects the register, i_cfg_wdata [7:0] is written
//
// Throughput is one word per cycle while m_axis does not stall; a tick's sample
// passes the input register, then the result register, onto m_axis; a start gives no word.
// The table read, the 8x8 multiply and the envelope update happen in the same cycle.
// Reset is synchronous: volume, step, count and periods clear, phase sits on
// the last entry. A stalled m_axis holds back tick words only; starts still pass.
module sine_tone_decay_generator_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] note_length
    input  logic        s_axis_tuser,   // [0] cmd
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] sample
    output logic        m_axis_tuser,   // [0] busy_res
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);
    import stdg_pkg::*;

    logic [7:0]  r_start_volume, r_ceiling, r_decay_begin, r_decay_limit;
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [15:0] r_in_len;
    logic        r_out_valid;
    logic [7:0]  r_out_sample;
    logic        r_out_busy;

    logic        fire;
    t_env_ctl    env_ctl;
    logic [3:0]  entry_idx;
    logic [7:0]  level;
    logic        busy_next;
    logic [7:0]  sample;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_volume <= RST_START_VOLUME;
            r_ceiling      <= RST_OUTPUT_CEILING;
            r_decay_begin  <= RST_DECAY_BEGIN;
            r_decay_limit  <= RST_DECAY_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_VOLUME:   r_start_volume <= i_cfg_wdata;
                CFG_OUTPUT_CEILING: r_ceiling      <= i_cfg_wdata;
                CFG_DECAY_BEGIN:    r_decay_begin  <= i_cfg_wdata;
                CFG_DECAY_LIMIT:    r_decay_limit  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // a held word is processed when it needs no slot or the slot frees up
    assign fire = r_in_valid &&
                  (r_in_cmd == CMD_START || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd <= s_axis_tuser;
            r_in_len <= s_axis_tdata;
        end
    end

    assign env_ctl.fire  = fire;
    assign env_ctl.start = (r_in_cmd == CMD_START);
    assign env_ctl.len   = r_in_len;

    stdg_env #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_env (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (env_ctl),
        .i_start_volume (r_start_volume),
        .i_decay_begin  (r_decay_begin),
        .i_decay_limit  (r_decay_limit),
        .o_entry_idx    (entry_idx),
        .o_level        (level),
        .o_busy_next    (busy_next)
    );

    stdg_sample u_sample (
        .i_entry_idx (entry_idx),
        .i_level     (level),
        .i_ceiling   (r_ceiling),
        .o_sample    (sample)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_cmd == CMD_TICK) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_cmd == CMD_TICK) begin
            r_out_sample <= sample;
            r_out_busy   <= busy_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sample;
    assign m_axis_tuser  = r_out_busy;

endmodule

// ===== design/stdg_checker.sv =====
module stdg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // with no result waiting, the input side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

bind sine_tone_decay_generator_top stdg_checker u_stdg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/tb.sv =====
module tb;

    import stdg_pkg::*;

    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 205;
    localparam int DRAIN_CYCLES = 6;        // input reg + result reg, with margin
    localparam int CYCLE_LIMIT  = 300000;
    localparam int IDLE_PCT     = 37;

    // one expected output word
    typedef struct packed {
        logic [7:0] sample;
        logic       busy;
    } t_tone_word;

    // directed stimulus table
    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [7:0]  val;
        logic        cmd;
        logic [15:0] len;
        logic [4:0]  reps;
        logic        typed;
        logic [7:0]  want_sample;
        logic        want_busy;
    } t_drill_row;

    localparam int DRILL_ROWS = 14;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // [15:0] note_length
    logic        s_axis_tuser  = 1'b0;   // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] sample
    logic        m_axis_tuser;           // [0] busy_res
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = '0;
    logic [7:0]  i_cfg_wdata   = '0;

    // tone predictor: registers and envelope state
    logic [7:0]  cfg_start_vol   = RST_START_VOLUME;
    logic [7:0]  cfg_ceiling     = RST_OUTPUT_CEILING;
    logic [7:0]  cfg_decay_from  = RST_DECAY_BEGIN;
    logic [7:0]  cfg_decay_limit = RST_DECAY_LIMIT;
    logic [3:0]  env_phase       = 4'(WAVE_ENTRIES - 1);
    logic [15:0] env_periods     = '0;
    logic [7:0]  env_vol         = '0;
    logic [7:0]  env_vol_step    = '0;
    logic [7:0]  env_age         = '0;

    t_tone_word  tone_samples [$];      // expected sample words, oldest first
    t_drill_row  drill [DRILL_ROWS];
    int          fail_cnt  = 0;
    int          cycle_cnt = 0;
    bit          calm      = 1'b0;      // no idling on either side

    sine_tone_decay_generator_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // advance the tone model by one accepted word
    task automatic tone_predict(input logic cmd, input logic [15:0] len,
                                output bit has_word, output t_tone_word w);
        logic [15:0] prod;
        w = '0;
        has_word = 1'b0;
        if (cmd == CMD_START) begin
            env_vol     = cfg_start_vol;
            env_age     = '0;
            env_phase   = '0;
            env_periods = len;
        end else begin
            prod     = 16'(WAVE_TABLE[env_phase]) * 16'(env_vol);
            w.sample = (prod[15:8] > cfg_ceiling) ? cfg_ceiling : prod[15:8];
            if (env_phase != 4'(WAVE_ENTRIES - 1)) begin
                env_phase = env_phase + 4'd1;
            end else if (env_periods != 0) begin
                // period boundary: count down, age the note, maybe decay
                env_phase   = '0;
                env_periods = env_periods - 16'd1;
                if (env_age != COUNT_MAX)
                    env_age = env_age + 8'd1;
                if (env_age >= cfg_decay_from) begin
                    if (env_vol_step == 0)
                        env_vol_step = env_vol / 8'd50;
                    // saturates when the volume is already below the step
                    env_vol = (env_vol > env_vol_step) ? env_vol - env_vol_step : 8'd0;
                    if (env_vol <= env_vol_step || env_age >= cfg_decay_limit) begin
                        env_vol_step = '0;
                        env_age      = '0;
                    end
                end
            end
            w.busy   = (env_periods != 0);
            has_word = 1'b1;
        end
    endtask

    function automatic void fail_note(string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("mismatch @%0d: %s", cycle_cnt, msg);
    endfunction

    // send one input word, idling at random first
    task automatic send_word(input logic cmd, input logic [15:0] len,
                             input bit typed, input t_tone_word typed_word);
        t_tone_word w;
        bit         has_w;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= len;
        do @(posedge i_clk); while (!s_axis_tready);
        tone_predict(cmd, len, has_w, w);
        if (has_w)
            tone_samples.push_back(typed ? typed_word : w);
    endtask

    // hold input until every expected word is out and the pipe is empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tone_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_START_VOLUME:   cfg_start_vol   = val;
            CFG_OUTPUT_CEILING: cfg_ceiling     = val;
            CFG_DECAY_BEGIN:    cfg_decay_from  = val;
            CFG_DECAY_LIMIT:    cfg_decay_limit = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic tone_setup(input logic [7:0] vol, input logic [7:0] ceil_val,
                              input logic [7:0] from_age, input logic [7:0] lim_age);
        cfg_write(CFG_START_VOLUME, vol);
        cfg_write(CFG_OUTPUT_CEILING, ceil_val);
        cfg_write(CFG_DECAY_BEGIN, from_age);
        cfg_write(CFG_DECAY_LIMIT, lim_age);
    endtask

    // output side: check each word, stall at random
    always @(posedge i_clk) begin
        t_tone_word w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tone_samples.size() == 0) begin
                fail_note($sformatf("word with none expected: sample %0d busy %0d",
                                    m_axis_tdata, m_axis_tuser));
            end else begin
                w = tone_samples.pop_front();
                if (m_axis_tdata !== w.sample)
                    fail_note($sformatf("sample: expected %0d, got %0d",
                                        w.sample, m_axis_tdata));
                if (m_axis_tuser !== w.busy)
                    fail_note($sformatf("busy: expected %0d, got %0d",
                                        w.busy, m_axis_tuser));
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int  left;
        int  ticks;
        bit  paused;
        logic [7:0] from_age;

        // kind, reg, value, cmd, length, repeats, typed, sample, busy
        drill = '{
            // volume is zero after reset
            '{ROW_WORD, CFG_START_VOLUME,   8'd0,   CMD_TICK,  16'd0,     5'd1,  1'b1, 8'd0, 1'b0},
            // length ignored on a tick; phase parked on the last entry
            '{ROW_WORD, CFG_START_VOLUME,   8'd0,   CMD_TICK,  16'hFFFF,  5'd1,  1'b1, 8'd0, 1'b0},
            '{ROW_REG,  CFG_OUTPUT_CEILING, 8'd0,   CMD_TICK,  16'd0,     5'd0,  1'b0, 8'd0, 1'b0},
            '{ROW_WORD, CFG_START_VOLUME,   8'd0,   CMD_START, 16'hFFFF,  5'd1,  1'b0, 8'd0, 1'b0},
            // zero ceiling clips everything
            '{ROW_WORD, CFG_START_VOLUME,   8'd0,   CMD_TICK,  16'd0,     5'd1,  1'b1, 8'd0, 1'b1},
            '{ROW_REG,  CFG_OUTPUT_CEILING, 8'd255, CMD_TICK,  16'd0,     5'd0,  1'b0, 8'd0, 1'b0},
            '{ROW_REG,  CFG_START_VOLUME,   8'd255, CMD_TICK,  16'd0,     5'd0,  1'b0, 8'd0, 1'b0},
            '{ROW_REG,  CFG_DECAY_BEGIN,    8'd0,   CMD_TICK,  16'd0,     5'd0,  1'b0, 8'd0, 1'b0},
            '{ROW_REG,  CFG_DECAY_LIMIT,    8'd255, CMD_TICK,  16'd0,     5'd0,  1'b0, 8'd0, 1'b0},
            '{ROW_WORD, CFG_START_VOLUME,   8'd0,   CMD_START, 16'd1,     5'd1,  1'b0, 8'd0, 1'b0},
            // one full period, decay step taken at its end
            '{ROW_WORD, CFG_START_VOLUME,   8'd0,   CMD_TICK,  16'd0,     5'd16, 1'b0, 8'd0, 1'b0},
            // no periods left: last entry repeats
            '{ROW_WORD, CFG_START_VOLUME,   8'd0,   CMD_TICK,  16'd0,     5'd1,  1'b0, 8'd0, 1'b0},
            // new note keeps the step
            '{ROW_WORD, CFG_START_VOLUME,   8'd0,   CMD_START, 16'd0,     5'd1,  1'b0, 8'd0, 1'b0},
            '{ROW_WORD, CFG_START_VOLUME,   8'd0,   CMD_TICK,  16'd0,     5'd1,  1'b0, 8'd0, 1'b0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (drill[r]) begin
            if (drill[r].kind == ROW_REG) begin
                wait_idle();
                cfg_write(drill[r].idx, drill[r].val);
            end else begin
                for (int k = 0; k < drill[r].reps; k++)
                    send_word(drill[r].cmd, drill[r].len, drill[r].typed,
                              {drill[r].want_sample, drill[r].want_busy});
            end
        end

        // random notes under several settings
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: tone_setup(8'd255, 8'd255, 8'd0, 8'd255);
                // start volume below the step left over from the last phase
                1: tone_setup(8'd3, 8'd255, 8'd0, 8'd255);
                2: tone_setup(8'd0, 8'd0, 8'd255, 8'd0);
                default: begin
                    from_age = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                        : 8'($urandom_range(3));
                    tone_setup(8'($urandom_range(255)), 8'($urandom_range(100, 255)),
                               from_age, 8'($urandom_range(255)));
                end
            endcase
            calm   = (p == 3);
            left   = PHASE_WORDS;
            paused = 1'b0;
            while (left > 0) begin
                // let the output run dry once mid-phase
                if (p == 0 && !paused && left < PHASE_WORDS / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 8) begin
                    // stray word, either kind
                    send_word(1'($urandom), 16'($urandom), 1'b0, '0);
                    left--;
                end else begin
                    send_word(CMD_START, ($urandom_range(3) == 0) ? 16'($urandom)
                                                                  : 16'($urandom_range(6)),
                              1'b0, '0);
                    left--;
                    ticks = $urandom_range(1, 70);
                    if (ticks > left)
                        ticks = left;
                    repeat (ticks) begin
                        send_word(CMD_TICK, 16'($urandom), 1'b0, '0);
                        left--;
                    end
                end
            end
            calm = 1'b0;
        end

        wait_idle();
        if (fail_cnt == 0 && tone_samples.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/stdg_pkg.sv
design/stdg_sample.sv
design/stdg_env.sv
design/sine_tone_decay_generator_top.sv
design/stdg_checker.sv
dv/tb.sv
